@@ design/mtl_pkg.sv @@
// Package for the motion-triggered light timer: field widths, CSR indexes,
// reset values of the configuration registers and the configuration struct.
// No dependencies.
package mtl_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int THRESH_W   = 16;
   localparam int HITS_W     = 4;
   localparam int TIMER_W    = 16;
   localparam int DEC_W      = 8;
   localparam int CSR_DATA_W = 16;

   // CSR register indexes
   typedef enum logic [1:0] {
      CSR_MOVE_THRESHOLD = 2'd0,
      CSR_HITS_NEEDED    = 2'd1,
      CSR_ON_TIME_LOAD   = 2'd2,
      CSR_TIME_DECREMENT = 2'd3
   } csr_index_type;

   localparam logic [THRESH_W-1:0] MOVE_THRESHOLD_RST = 16'd200;
   localparam logic [HITS_W-1:0]   HITS_NEEDED_RST    = 4'd2;
   localparam logic [TIMER_W-1:0]  ON_TIME_LOAD_RST   = 16'd60;
   localparam logic [DEC_W-1:0]    TIME_DECREMENT_RST = 8'd2;
   localparam logic [HITS_W-1:0]   HIT_RUN_MAX        = 4'd15;

   typedef struct packed {
      logic [THRESH_W-1:0] move_threshold;
      logic [HITS_W-1:0]   hits_needed;
      logic [TIMER_W-1:0]  on_time_load;
      logic [DEC_W-1:0]    time_decrement;
   } cfg_type;

endpackage

@@ design/mtl_if.sv @@
// Valid/ready channel interfaces for the motion-triggered light timer:
// the sample request channel and the result response channel.
// Depends on mtl_pkg.
interface mtl_req_if;
   import mtl_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_x;
   logic signed [SAMPLE_W-1:0] sample_y;

   modport source (output valid, output sample_x, output sample_y, input ready);
   modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface mtl_rsp_if;
   import mtl_pkg::*;

   logic               valid;
   logic               ready;
   logic               movement_seen;
   logic               light_on;
   logic [TIMER_W-1:0] time_left;

   modport source (output valid, output movement_seen, output light_on, output time_left,
                   input ready);
   modport sink   (input valid, input movement_seen, input light_on, input time_left,
                   output ready);
endinterface

@@ design/mtl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/mtl_dev.sv @@
// Deviation check for one axis: mean = running sum / WINDOW truncated toward
// zero (exact reciprocal multiply), then |mean - sample| > threshold.
// Depends on mtl_pkg.
module mtl_dev #(
   parameter int WINDOW = 8
) (
   input  logic signed [mtl_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] sum,
   input  logic signed [mtl_pkg::SAMPLE_W-1:0]                sample,
   input  logic        [mtl_pkg::THRESH_W-1:0]                threshold,
   output logic                                               deviates
);
   import mtl_pkg::*;

   localparam int L     = $clog2(WINDOW);
   localparam int SUM_W = SAMPLE_W + L;
   localparam int PRD_W = 2 * SUM_W + 1;
   localparam int Q_W   = SAMPLE_W + 1;
   localparam int D_W   = SAMPLE_W + 2;
   // ceil(2^(SUM_W+L) / WINDOW): exact floor division for magnitudes below 2^SUM_W
   localparam longint MULT_FULL =
      ((longint'(1) << (SUM_W + L)) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam logic [63:0] MULT_BITS = 64'(MULT_FULL);
   localparam logic [SUM_W:0] MULT = MULT_BITS[SUM_W:0];

   logic [SUM_W-1:0]        mag;
   logic [PRD_W-1:0]        prod;
   logic [Q_W-1:0]          quo;
   logic signed [D_W-1:0]   quo_s;
   logic signed [D_W-1:0]   mean;
   logic signed [D_W-1:0]   diff;
   logic [D_W-1:0]          abs_dev;

   // divide the magnitude of the sum, then restore the sign (truncate toward zero)
   always_comb begin
      mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      prod  = PRD_W'(mag) * PRD_W'(MULT);
      quo   = prod[SUM_W+L +: Q_W];
      quo_s = signed'(D_W'(quo));
      mean  = sum[SUM_W-1] ? -quo_s : quo_s;
   end

   // absolute deviation against the threshold
   always_comb begin
      diff     = mean - signed'({{(D_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample});
      abs_dev  = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
      deviates = abs_dev > D_W'(threshold);
   end

endmodule

@@ design/motion_triggered_light_timer_core.sv @@
// Motion-triggered light timer. Takes one signed X/Y sample per item and returns
// one result item per sample: movement flag, light state and remaining on-time.
// An item is accepted every clock cycle while the result side keeps up; a result
// is offered from the result register after its sample has passed the input
// register, where a stall on the result side can hold it. The state update, that
// is the running-sum add and subtract, a reciprocal-multiply mean and the
// threshold compare, lies entirely between the input register and the result
// register. The sample history sits in a RAM of WINDOW entries read one item
// ahead; entries not yet written since reset read as zero, so no clearing pass
// is needed after reset.
// Depends on mtl_pkg, mtl_if, mtl_ram and mtl_dev.
module motion_triggered_light_timer_core #(
   parameter int WINDOW = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   mtl_req_if.sink                           req,
   mtl_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  mtl_pkg::csr_index_type            csr_index,
   input  logic [mtl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mtl_pkg::*;

   localparam int POS_W = $clog2(WINDOW);
   localparam int SUM_W = SAMPLE_W + POS_W;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

   // configuration
   cfg_type cfg_ff, cfg_in;

   // input stage
   logic                       in_valid_ff, in_valid_in;
   logic signed [SAMPLE_W-1:0] in_x_ff, in_y_ff;

   // detector state
   logic signed [SUM_W-1:0]    sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       filled_ff, filled_in;
   logic [HITS_W-1:0]          hit_ff, hit_in;
   logic [TIMER_W-1:0]         timer_ff, timer_in;

   // result stage
   logic                       out_valid_ff, out_valid_in;
   logic                       out_moved_ff;
   logic [TIMER_W-1:0]         out_time_ff;

   logic                       out_free, advance;
   logic [2*SAMPLE_W-1:0]      ram_rd;
   logic signed [SAMPLE_W-1:0] old_x, old_y;
   logic                       dev_x, dev_y, moved;
   logic [TIMER_W-1:0]         timer_dec;
   logic [HITS_W-1:0]          hit_next;

   // CSR writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MOVE_THRESHOLD: cfg_in.move_threshold = THRESH_W'(csr_wdata);
            CSR_HITS_NEEDED:    cfg_in.hits_needed    = csr_wdata[HITS_W-1:0];
            CSR_ON_TIME_LOAD:   cfg_in.on_time_load   = TIMER_W'(csr_wdata);
            CSR_TIME_DECREMENT: cfg_in.time_decrement = csr_wdata[DEC_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_threshold <= MOVE_THRESHOLD_RST;
         cfg_ff.hits_needed    <= HITS_NEEDED_RST;
         cfg_ff.on_time_load   <= ON_TIME_LOAD_RST;
         cfg_ff.time_decrement <= TIME_DECREMENT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: the input register drains whenever the result register can take an item
   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // capture the sample
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_x_ff <= req.sample_x;
         in_y_ff <= req.sample_y;
      end
   end

   // history ring: read data holds the entry at pos_ff, which the current item replaces
   mtl_ram #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (pos_ff),
      .wr_data ({in_x_ff, in_y_ff}),
      .rd_addr (pos_in),
      .rd_data (ram_rd)
   );

   // entries not written since reset read as zero
   assign old_x = filled_ff ? signed'(ram_rd[2*SAMPLE_W-1:SAMPLE_W]) : '0;
   assign old_y = filled_ff ? signed'(ram_rd[SAMPLE_W-1:0]) : '0;

   // movement against the mean of the previous window
   mtl_dev #(.WINDOW(WINDOW)) u_dev_x (
      .sum       (sum_x_ff),
      .sample    (in_x_ff),
      .threshold (cfg_ff.move_threshold),
      .deviates  (dev_x)
   );

   mtl_dev #(.WINDOW(WINDOW)) u_dev_y (
      .sum       (sum_y_ff),
      .sample    (in_y_ff),
      .threshold (cfg_ff.move_threshold),
      .deviates  (dev_y)
   );

   assign moved = dev_x || dev_y;

   // timer drop, hit run and reload
   always_comb begin
      timer_dec = (timer_ff > TIMER_W'(cfg_ff.time_decrement)) ?
                  timer_ff - TIMER_W'(cfg_ff.time_decrement) : '0;
      if (moved) begin
         hit_next = (hit_ff == HIT_RUN_MAX) ? HIT_RUN_MAX : hit_ff + 1'b1;
      end else begin
         hit_next = '0;
      end
   end

   // next state, advanced only when an item moves to the result register
   always_comb begin
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      pos_in    = pos_ff;
      filled_in = filled_ff;
      hit_in    = hit_ff;
      timer_in  = timer_ff;
      if (advance) begin
         sum_x_in = sum_x_ff + {{POS_W{in_x_ff[SAMPLE_W-1]}}, in_x_ff}
                             - {{POS_W{old_x[SAMPLE_W-1]}}, old_x};
         sum_y_in = sum_y_ff + {{POS_W{in_y_ff[SAMPLE_W-1]}}, in_y_ff}
                             - {{POS_W{old_y[SAMPLE_W-1]}}, old_y};
         pos_in    = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
         filled_in = filled_ff || (pos_ff == POS_LAST);
         hit_in    = hit_next;
         timer_in  = (moved && (hit_next >= cfg_ff.hits_needed)) ?
                     cfg_ff.on_time_load : timer_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         pos_ff    <= '0;
         filled_ff <= 1'b0;
         hit_ff    <= '0;
         timer_ff  <= '0;
      end else begin
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         pos_ff    <= pos_in;
         filled_ff <= filled_in;
         hit_ff    <= hit_in;
         timer_ff  <= timer_in;
      end
   end

   // result register
   assign out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_moved_ff <= moved;
         out_time_ff  <= timer_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.movement_seen = out_moved_ff;
   assign rsp.light_on      = (out_time_ff != '0);
   assign rsp.time_left     = out_time_ff;

endmodule
